// ===== rtl/core/sem_pkg.sv =====
// Shared constants and types for the Sobel edge magnitude block.
package sem_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 12;
  localparam int WIDTH_W      = 12;
  localparam int HEIGHT_W     = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIN_DIM      = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  typedef struct packed {
    logic [15:0] energy;
    logic        row_end;
    logic        frame_end;
  } sem_job_t;

endpackage

// ===== rtl/core/sem_pixel_if.sv =====
// Input channel carrying one RGB pixel per transaction.
interface sem_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/sem_edge_if.sv =====
// Result channel carrying one edge magnitude per transaction.
interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_level;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, output edge_level, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input edge_level, input row_end, input frame_end,
                output ready);
endinterface

// ===== rtl/core/sem_front.sv =====
// Front end: pixel intake, gray conversion, line stores, window and Sobel energy.
module sem_front (
  input  logic                          clk,
  input  logic                          rst_n,
  sem_pixel_if.sink                     pix,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          push,
  input  logic                          full,
  output sem_pkg::sem_job_t             job
);
  import sem_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]          state_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    colq_r;
  logic [7:0]          gray_r;
  logic [7:0]          top_r;
  logic [7:0]          mid_r;
  logic                interior_r;
  logic                row_end_r;
  logic                frame_end_r;
  logic [7:0]          win_r [9];
  logic signed [10:0]  sx_r;
  logic signed [10:0]  sy_r;

  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];

  logic [WIDTH_W-1:0]  act_w;
  logic [HEIGHT_W-1:0] act_h;
  logic                accept;
  logic                last_col;
  logic                last_row;
  logic [12:0]         gray_sum;
  logic [10:0]         sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [21:0]  sx_sq, sy_sq;
  logic [21:0]         energy;

  always_comb begin
    act_w = width_r;
    if (int'(width_r) < MIN_DIM) act_w = WIDTH_W'(MIN_DIM);
    else if (int'(width_r) > MAX_WIDTH) act_w = WIDTH_W'(MAX_WIDTH);
    act_h = height_r;
    if (int'(height_r) < MIN_DIM) act_h = HEIGHT_W'(MIN_DIM);
    else if (int'(height_r) > HEIGHT_LIMIT) act_h = HEIGHT_W'(HEIGHT_LIMIT);
  end

  assign pix.ready = (state_r == ST_IDLE);
  assign accept    = pix.valid && pix.ready;
  assign last_col  = (int'(col_r) + 1 >= int'(act_w));
  assign last_row  = (int'(row_r) + 1 >= int'(act_h));
  assign gray_sum  = 13'd11 * 13'(pix.red) + 13'd16 * 13'(pix.green)
                   + 13'd5 * 13'(pix.blue);

  assign sx_pos = 11'(win_r[2]) + {2'b0, win_r[5], 1'b0} + 11'(win_r[8]);
  assign sx_neg = 11'(win_r[0]) + {2'b0, win_r[3], 1'b0} + 11'(win_r[6]);
  assign sy_pos = 11'(win_r[6]) + {2'b0, win_r[7], 1'b0} + 11'(win_r[8]);
  assign sy_neg = 11'(win_r[0]) + {2'b0, win_r[1], 1'b0} + 11'(win_r[2]);

  assign sx_sq  = sx_r * sx_r;
  assign sy_sq  = sy_r * sy_r;
  assign energy = 22'(sx_sq[20:0]) + 22'(sy_sq[20:0]);

  assign push          = (state_r == ST_PUSH) && interior_r && !full;
  assign job.energy    = (|energy[21:16]) ? 16'hFFFF : energy[15:0];
  assign job.row_end   = row_end_r;
  assign job.frame_end = frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) begin
        if (cfg_index == CFG_FRAME_WIDTH) width_r <= cfg_data[WIDTH_W-1:0];
        else height_r <= cfg_data;
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) state_r <= ST_WIN;
        end
        ST_WIN: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k*3]   <= win_r[k*3+1];
            win_r[k*3+1] <= win_r[k*3+2];
          end
          win_r[2] <= top_r;
          win_r[5] <= mid_r;
          win_r[8] <= gray_r;
          state_r  <= ST_SUM;
        end
        ST_SUM: begin
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!interior_r || !full) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gray_r      <= gray_sum[12:5];
      colq_r      <= col_r;
      interior_r  <= (int'(row_r) >= 2) && (int'(col_r) >= 2);
      row_end_r   <= last_col;
      frame_end_r <= last_col && last_row;
    end
    if (state_r == ST_SUM) begin
      sx_r <= $signed(sx_pos - sx_neg);
      sy_r <= $signed(sy_pos - sy_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r <= upper_mem[col_r];
      mid_r <= middle_mem[col_r];
    end
    if (state_r == ST_WIN) begin
      upper_mem[colq_r]  <= mid_r;
      middle_mem[colq_r] <= gray_r;
    end
  end

  a_accept_to_win: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |=> state_r == ST_WIN)
    else $error("accepted pixel did not start the window update");

endmodule

// ===== rtl/core/sem_queue.sv =====
// Short job queue between the front end and the square root back end.
module sem_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sem_pkg::sem_job_t push_job,
  output logic              full,
  input  logic              pop,
  output sem_pkg::sem_job_t pop_job,
  output logic              empty
);
  import sem_pkg::*;

  sem_job_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign full    = (int'(count_r) == QUEUE_DEPTH);
  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job popped from an empty queue");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a pushed job");

endmodule

// ===== rtl/core/sem_back.sv =====
// Back end: integer sqrt at two bits per unstalled cycle; output register.
module sem_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  sem_pkg::sem_job_t job,
  output logic              pop,
  sem_edge_if.source        edge_out
);
  import sem_pkg::*;

  logic        busy_r;
  logic [1:0]  step_r;
  logic [15:0] val_r;
  logic [10:0] rem_r;
  logic [7:0]  root_r;
  logic        row_end_r;
  logic        frame_end_r;
  logic        out_valid_r;
  logic [7:0]  level_r;
  logic        out_row_end_r;
  logic        out_frame_end_r;

  logic [15:0] val_nxt;
  logic [10:0] rem_nxt;
  logic [7:0]  root_nxt;
  logic [10:0] trial;
  logic        last;
  logic        out_free;
  logic        advance;
  logic        finish;

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    trial    = '0;
    for (int k = 0; k < 2; k++) begin
      rem_nxt = {rem_nxt[8:0], val_nxt[15:14]};
      val_nxt = {val_nxt[13:0], 2'b00};
      trial   = {1'b0, root_nxt, 2'b01};
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_nxt[6:0], 1'b1};
      end else begin
        root_nxt = {root_nxt[6:0], 1'b0};
      end
    end
  end

  assign last     = (step_r == 2'd3);
  assign out_free = !out_valid_r || edge_out.ready;
  assign advance  = busy_r && (!last || out_free);
  assign finish   = advance && last;
  assign pop      = (!busy_r || finish) && !empty;

  assign edge_out.valid      = out_valid_r;
  assign edge_out.edge_level = level_r;
  assign edge_out.row_end    = out_row_end_r;
  assign edge_out.frame_end  = out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (finish) begin
        busy_r <= 1'b0;
      end else if (advance) begin
        step_r <= step_r + 1'b1;
      end
      if (finish) out_valid_r <= 1'b1;
      else if (edge_out.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      val_r       <= job.energy;
      rem_r       <= '0;
      root_r      <= '0;
      row_end_r   <= job.row_end;
      frame_end_r <= job.frame_end;
    end else if (advance) begin
      val_r  <= val_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
    if (finish) begin
      level_r         <= root_nxt;
      out_row_end_r   <= row_end_r;
      out_frame_end_r <= frame_end_r;
    end
  end

  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> out_free)
    else $error("result overwrote a transaction still waiting");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> busy_r && step_r == 2'd0)
    else $error("popped job did not start the root sequence");

endmodule

// ===== rtl/core/sobel_edge_magnitude.sv =====
// Top level of the Sobel edge magnitude block.
//
// Usage: in_pixel carries RGB pixels in raster order, one per transaction.
// out_edge carries one gradient magnitude per interior pixel, with row_end
// on the last interior pixel of a row and frame_end on the last of the frame.
// The result of a pixel follows the transaction of the pixel one row below
// and one column to its right; border pixels give no result.
// Frame width and height are written through cfg_we/cfg_index/cfg_data
// while the block is idle; a write restarts the frame at row and column zero.
// Pacing: the front end takes a new pixel only after its sequence of
// line-store read, window update, Sobel sums and squaring has ended, which
// waits on a full job queue; the square root back end takes one job at a time.
// With an empty queue and a ready receiver, a result passes the job queue and
// the square root steps before the result register holds it.
// Reset: sizes return to 640 by 480 and the counters to zero; the line
// stores are not cleared, as their stale entries never reach an output.
// When the receiver stalls, the result register holds, the back end and a
// 4-entry job queue fill, and then in_pixel.ready stays low.
module sobel_edge_magnitude (
  input  logic                          clk,
  input  logic                          rst_n,
  sem_pixel_if.sink                     in_pixel,
  sem_edge_if.source                    out_edge,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sem_pkg::*;

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  sem_job_t push_job;
  sem_job_t pop_job;

  sem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .job       (push_job)
  );

  sem_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  sem_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .job      (pop_job),
    .pop      (pop),
    .edge_out (out_edge)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Sobel edge magnitude block.
module tb;
  import sem_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [7:0] level;
    logic       row_end;
    logic       frame_end;
  } gradient_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    gradient_t  gradient;
  } pixel_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
    bit                    resize;
    int                    pixels;
  } frame_phase_t;

  localparam gradient_t NO_CHECK  = '0;
  localparam gradient_t FLAT_EDGE = '{8'd0, 1'b1, 1'b1};
  localparam gradient_t FULL_EDGE = '{8'd255, 1'b1, 1'b1};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sem_pixel_if pixel_ch ();
  sem_edge_if  edge_ch ();

  sobel_edge_magnitude i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (pixel_ch),
    .out_edge  (edge_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Three 3x3 frames: black, a white left column, then mixed primaries.
  pixel_row_t directed_rows [27] = '{
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b1, FLAT_EDGE},
    '{8'd255, 8'd255, 8'd255, 1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd255, 8'd255, 8'd255, 1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd255, 8'd255, 8'd255, 1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd0,   1'b1, FULL_EDGE},
    '{8'd255, 8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd255, 8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd255, 1'b0, NO_CHECK},
    '{8'd0,   8'd0,   8'd255, 1'b0, NO_CHECK},
    '{8'd128, 8'd64,  8'd32,  1'b0, NO_CHECK},
    '{8'd255, 8'd0,   8'd0,   1'b0, NO_CHECK},
    '{8'd0,   8'd255, 8'd0,   1'b0, NO_CHECK},
    '{8'd1,   8'd2,   8'd4,   1'b0, NO_CHECK},
    '{8'd255, 8'd255, 8'd0,   1'b0, NO_CHECK}
  };

  // Sizes below the minimum and above the maximum are included on purpose.
  frame_phase_t frame_phases [8] = '{
    '{13'd5,    13'd4,    1'b1, 63},
    '{13'd0,    13'd0,    1'b0, 37},
    '{13'd1,    13'h1FFF, 1'b1, 60},
    '{13'h1FFF, 13'd2,    1'b1, 30},
    '{13'd7,    13'd5,    1'b1, 50},
    '{13'd3,    13'd3,    1'b1, 30},
    '{13'd16,   13'd6,    1'b1, 60},
    '{13'd4,    13'd4096, 1'b1, 50}
  };

  gradient_t        pending_gradients [$];
  bit [7:0]         upper_gray [MAX_WIDTH];
  bit [7:0]         middle_gray [MAX_WIDTH];
  bit [7:0]         gray_win [9];
  logic [WIDTH_W-1:0]  width_reg  = RESET_WIDTH;
  logic [HEIGHT_W-1:0] height_reg = RESET_HEIGHT;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  int               error_count = 0;
  int               burst_left = 0;
  int               quiet_cycles = 0;
  logic [15:0]      stall_pattern = 16'hFFFF;
  int unsigned      pattern_age = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic predict_gradient(input logic [7:0] red, input logic [7:0] green,
                                  input logic [7:0] blue, input logic known,
                                  input gradient_t typed);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    int unsigned sq;
    int unsigned root;
    int unsigned trial;
    int unsigned mask;
    int          sx;
    int          sy;
    int          k;
    bit [7:0]    gray;
    gradient_t   result;
    w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < MIN_DIM) ? MIN_DIM :
        (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    gray = 8'((11 * int'(red) + 16 * int'(green) + 5 * int'(blue)) >> 5);
    idx = col_pos % MAX_WIDTH;
    for (k = 0; k < 3; k++) begin
      gray_win[3*k]   = gray_win[3*k+1];
      gray_win[3*k+1] = gray_win[3*k+2];
    end
    gray_win[2] = upper_gray[idx];
    gray_win[5] = middle_gray[idx];
    gray_win[8] = gray;
    upper_gray[idx]  = middle_gray[idx];
    middle_gray[idx] = gray;
    if (row_pos >= 2 && col_pos >= 2) begin
      sx = (int'(gray_win[2]) + 2 * int'(gray_win[5]) + int'(gray_win[8]))
         - (int'(gray_win[0]) + 2 * int'(gray_win[3]) + int'(gray_win[6]));
      sy = (int'(gray_win[6]) + 2 * int'(gray_win[7]) + int'(gray_win[8]))
         - (int'(gray_win[0]) + 2 * int'(gray_win[1]) + int'(gray_win[2]));
      sq = sx * sx + sy * sy;
      // An eight-bit root tops out at 255, which is the saturation.
      root = 0;
      for (mask = 128; mask != 0; mask = mask >> 1) begin
        trial = root | mask;
        if (trial * trial <= sq) root = trial;
      end
      result.level     = root[7:0];
      result.row_end   = (col_pos == w - 1);
      result.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
      pending_gradients.push_back(known ? typed : result);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_FRAME_WIDTH: begin
        width_reg = data[WIDTH_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = data[HEIGHT_W-1:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic known,
                            input gradient_t typed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        pixel_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_ch.valid <= 1'b1;
    pixel_ch.red   <= red;
    pixel_ch.green <= green;
    pixel_ch.blue  <= blue;
    do @(posedge clk); while (!pixel_ch.ready);
    predict_gradient(red, green, blue, known, typed);
  endtask

  task automatic drain_results(input int settle);
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_gradients.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    logic [7:0] shade;
    logic [7:0] red_v;
    logic [7:0] green_v;
    logic [7:0] blue_v;
    int         hold_at;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FRAME_WIDTH;
    cfg_data       = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.red   = '0;
    pixel_ch.green = '0;
    pixel_ch.blue  = '0;
    edge_ch.ready  = 1'b1;
    shade          = 8'd128;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(CFG_FRAME_WIDTH, 13'd3);
    cfg_write(CFG_FRAME_HEIGHT, 13'd0);
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                 directed_rows[i].known, directed_rows[i].gradient);
    end

    foreach (frame_phases[p]) begin
      drain_results(SETTLE_CYCLES);
      if (frame_phases[p].resize) begin
        cfg_write(CFG_FRAME_WIDTH, frame_phases[p].width);
        cfg_write(CFG_FRAME_HEIGHT, frame_phases[p].height);
      end else begin
        // Writes to unused indexes must leave the frame position alone.
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, '0);
      end
      hold_at = $urandom_range(0, frame_phases[p].pixels - 1);
      for (int n = 0; n < frame_phases[p].pixels; n++) begin
        if (n == hold_at) drain_results(0);
        if ($urandom_range(0, 2) == 0) begin
          {red_v, green_v, blue_v} = 24'($urandom);
        end else begin
          red_v   = shade + 8'($urandom_range(0, 12));
          green_v = shade + 8'($urandom_range(0, 12));
          blue_v  = shade + 8'($urandom_range(0, 12));
        end
        if ($urandom_range(0, 15) == 0) shade = 8'($urandom);
        send_pixel(red_v, green_v, blue_v, 1'b0, NO_CHECK);
      end
    end

    drain_results(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern <= 16'hFFFF;
        1:       stall_pattern <= 16'($urandom);
        2:       stall_pattern <= 16'h8000;
        default: stall_pattern <= 16'h00FF;
      endcase
      pattern_age <= $urandom_range(50, 300);
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      pattern_age   <= pattern_age - 1;
    end
    edge_ch.ready <= stall_pattern[15];
  end

  always @(posedge clk) begin
    gradient_t want;
    if (rst_n && edge_ch.valid && edge_ch.ready) begin
      if (pending_gradients.size() == 0) begin
        $error("unexpected transaction: edge_level %0d, row_end %0b, frame_end %0b",
               edge_ch.edge_level, edge_ch.row_end, edge_ch.frame_end);
        error_count++;
      end else begin
        want = pending_gradients.pop_front();
        if (edge_ch.edge_level !== want.level) begin
          $error("edge_level: expected %0d, actual %0d", want.level, edge_ch.edge_level);
          error_count++;
        end
        if (edge_ch.row_end !== want.row_end) begin
          $error("row_end: expected %0b, actual %0b", want.row_end, edge_ch.row_end);
          error_count++;
        end
        if (edge_ch.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, edge_ch.frame_end);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_ch.valid && pixel_ch.ready) || (edge_ch.valid && edge_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
